// ----- rtl/core/twfd_pkg.sv -----
// ----------------------------------------------------------------------------
// twfd_pkg
// shared types and constants of the tagged word frame deframer
// ----------------------------------------------------------------------------
package twfd_pkg;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_START_TAG = 8'd0,
		CFG_HEADER_OVERHEAD = 8'd1
	} cfg_idx_t;

	localparam logic [15:0] RST_FRAME_START_TAG = 16'hC500;
	localparam logic [15:0] RST_HEADER_OVERHEAD = 16'd10;

	// payload words are four bytes
	localparam logic [16:0] WORD_BYTES = 17'd4;

	typedef struct packed {
		logic [15:0] frame_start_tag;
		logic [15:0] header_overhead;
	} cfg_t;

	typedef struct packed {
		logic        message_corrupt;
		logic        resync_seen;
		logic [31:0] frame_id;
		logic        frame_done;
		logic [31:0] payload_data;
		logic [15:0] byte_offset;
		logic        payload_valid;
	} result_t;

endpackage

// ----- rtl/core/twfd_step.sv -----
// ----------------------------------------------------------------------------
// twfd_step
// framing state and per-word decode, one link word per enabled cycle
// ----------------------------------------------------------------------------
module twfd_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [31:0]        word,
	input  logic               last,
	input  twfd_pkg::cfg_t     cfg,
	output twfd_pkg::result_t  res
);

	logic        in_frame_q,  in_frame_d;
	logic [31:0] frame_num_q, frame_num_d;
	logic [15:0] byte_cnt_q,  byte_cnt_d;
	logic [17:0] exp_bytes_q, exp_bytes_d;
	logic        reject_q,    reject_d;
	logic        skip_q,      skip_d;
	logic [16:0] next_cnt;

	assign next_cnt = {1'b0, byte_cnt_q} + twfd_pkg::WORD_BYTES;

	always_comb begin
		in_frame_d  = in_frame_q;
		frame_num_d = frame_num_q;
		byte_cnt_d  = byte_cnt_q;
		exp_bytes_d = exp_bytes_q;
		reject_d    = reject_q;
		skip_d      = skip_q;
		res         = '0;
		if (skip_q) begin
			// rest of a message after completion is dropped
			if (last) begin
				skip_d = 1'b0;
			end
		end else if (word[31:16] == cfg.frame_start_tag) begin
			if (byte_cnt_q != 16'd0) begin
				res.resync_seen = 1'b1;
				byte_cnt_d      = 16'd0;
			end
			in_frame_d  = 1'b1;
			reject_d    = 1'b0;
			frame_num_d = 32'd0;
			exp_bytes_d = {2'b00, word[15:0]} - {2'b00, cfg.header_overhead};
		end else if (!reject_q) begin
			if (in_frame_q) begin
				if (frame_num_q != 32'd0) begin
					res.payload_valid = 1'b1;
					res.byte_offset   = byte_cnt_q;
					res.payload_data  = word;
					if ($signed({2'b00, next_cnt}) >= $signed({exp_bytes_q[17], exp_bytes_q})) begin
						res.frame_done = 1'b1;
						res.frame_id   = frame_num_q;
						byte_cnt_d     = 16'd0;
						exp_bytes_d    = 18'd0;
						in_frame_d     = 1'b0;
						skip_d         = !last;
					end else begin
						byte_cnt_d = next_cnt[15:0];
					end
				end else begin
					// zero means the frame number is still to come
					frame_num_d = word;
				end
			end else begin
				reject_d = 1'b1;
			end
		end
		res.message_corrupt = last && !res.frame_done && reject_d &&
			!res.payload_valid && !res.resync_seen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			frame_num_q <= 32'd0;
			byte_cnt_q  <= 16'd0;
			exp_bytes_q <= 18'd0;
			reject_q    <= 1'b0;
			skip_q      <= 1'b0;
		end else if (en) begin
			in_frame_q  <= in_frame_d;
			frame_num_q <= frame_num_d;
			byte_cnt_q  <= byte_cnt_d;
			exp_bytes_q <= exp_bytes_d;
			reject_q    <= reject_d;
			skip_q      <= skip_d;
		end
	end

endmodule

// ----- rtl/core/tagged_word_frame_deframer_top.sv -----
// ----------------------------------------------------------------------------
// tagged_word_frame_deframer_top
// splits tagged 32-bit link words into frame headers, numbers and payload
// ----------------------------------------------------------------------------
// Every accepted link word gives exactly one result transaction, in order.
// The block runs at one word per cycle as long as results are taken: a
// word is registered at the input stage, decoded combinationally against
// the framing state, and held as a result in an output register, from
// which it is offered to the output side; the
// input side keeps taking a word every cycle as long as the output side
// takes results. Configuration writes (start tag, header overhead) are always
// accepted and must only be issued while no word is in flight.
// ----------------------------------------------------------------------------
module tagged_word_frame_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [twfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [twfd_pkg::CFG_DATA_W-1:0]  cfg_data,
	// link words in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] link_word
	input  logic        s_tlast,   // message_end
	// results out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [15:0] byte_offset, [47:16] payload_data,
	                               // [79:48] frame_id
	output logic [3:0]  m_tuser    // [0] payload_valid, [1] frame_done,
	                               // [2] resync_seen, [3] message_corrupt
);

	twfd_pkg::cfg_t    cfg_q;
	twfd_pkg::result_t res;
	twfd_pkg::result_t res_q;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        last_s1;
	logic        out_valid_q;
	logic        adv;     // input stage hands its word to the output register

	// configuration registers, unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_start_tag <= twfd_pkg::RST_FRAME_START_TAG;
			cfg_q.header_overhead <= twfd_pkg::RST_HEADER_OVERHEAD;
		end else if (cfg_valid) begin
			case (cfg_index)
				twfd_pkg::CFG_FRAME_START_TAG: cfg_q.frame_start_tag <= cfg_data;
				twfd_pkg::CFG_HEADER_OVERHEAD: cfg_q.header_overhead <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: output register free or draining this cycle
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// decode and framing state, advanced once per word
	twfd_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.word   (word_s1),
		.last   (last_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_q.frame_id, res_q.payload_data, res_q.byte_offset};
	assign m_tuser  = {res_q.message_corrupt, res_q.resync_seen,
		res_q.frame_done, res_q.payload_valid};

	// a completed frame always comes with its last payload word
	a_done_has_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("frame_done without payload_valid");

	// a resync is a header word: no payload and no corrupt flag with it
	a_resync_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> !m_tuser[0] && !m_tuser[3])
		else $error("resync_seen with payload or corrupt");

	// non-payload results carry zero offset, data and id
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 80'd0)
		else $error("fields set on a non-payload result");

	// a word waiting in the input stage blocks new input until it moves
	a_s1_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !s_tready)
		else $error("input taken while input stage is stalled");

endmodule
